// ===== rtl/bdrq_pkg.sv =====
// shared types, constants and helpers of the button debounce report queue
package bdrq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int MAX_BUTTONS = 8;
	localparam int CMD_DEPTH   = 2;

	localparam int BTN_W      = 8;
	localparam int BCNT_W     = 4;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int RS_W       = 8;
	localparam int ACK_W      = 8;
	localparam int IDX_OUT_W  = 3;
	localparam int TOTAL_W    = 4;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QS_W = QA_W + 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CP_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CC_W = $clog2(CMD_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_COUNT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRANSMIT_TICKS = 1'b1;

	localparam logic [RS_W-1:0] RS_COUNTING_OFF = 8'h80;
	localparam logic [RS_W-1:0] RS_PENDING      = 8'hff;
	localparam logic [RS_W-1:0] RS_ACKED        = 8'hfe;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_ACK     = 2'd1,
		OP_SEND    = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_REPORT = 2'd2,
		KIND_NOSEND = 2'd3
	} kind_t;

	typedef struct packed {
		op_t              op;
		logic [BTN_W-1:0] arg;
	} cmd_t;

	typedef struct packed {
		kind_t                kind;
		logic                 wake;
		logic [BTN_W-1:0]     pressed_state;
		logic [BTN_W-1:0]     report_byte;
		logic [IDX_OUT_W-1:0] report_index;
		logic [TOTAL_W-1:0]   report_total;
		logic [ACK_W-1:0]     ack_total;
		logic                 last;
	} res_t;

	// circular queue address, both operands below the depth
	function automatic logic [QA_W-1:0] qwrap(input logic [QA_W-1:0] base,
		input logic [QA_W-1:0] offs);
		logic [QS_W-1:0] sum;
		sum = {1'b0, base} + {1'b0, offs};
		if (sum >= QS_W'(QUEUE_DEPTH)) begin
			sum = sum - QS_W'(QUEUE_DEPTH);
		end
		return sum[QA_W-1:0];
	endfunction

endpackage

// ===== rtl/bdrq_ram.sv =====
// generic single write port ram with registered read
module bdrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ===== rtl/bdrq_front.sv =====
// front end: input transfer, command decode and button masking, command queue
module bdrq_front import bdrq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,  // sample_bits, ack_amount, initial_state
	input  logic [1:0]           s_axis_tuser,  // mode
	input  logic [BCNT_W-1:0]    active_buttons,
	output logic                 cmd_valid,
	output cmd_t                 cmd,
	input  logic                 cmd_ready
);

	logic [BCNT_W-1:0] n_btn;
	logic [BTN_W-1:0]  mask;
	cmd_t              cmd_in;
	logic              push;
	logic              pop;

	cmd_t              fifo_q [CMD_DEPTH];
	logic [CP_W-1:0]   wr_ptr_q;
	logic [CP_W-1:0]   rd_ptr_q;
	logic [CC_W-1:0]   cnt_q;

	always_comb begin
		n_btn = (active_buttons > BCNT_W'(MAX_BUTTONS)) ? BCNT_W'(MAX_BUTTONS) : active_buttons;
		for (int i = 0; i < BTN_W; i++) begin
			mask[i] = (BCNT_W'(i) < n_btn);
		end
		cmd_in.op = op_t'(s_axis_tuser);
		unique case (op_t'(s_axis_tuser))
			OP_TICK:    cmd_in.arg = s_axis_tdata[7:0] & mask;
			OP_ACK:     cmd_in.arg = s_axis_tdata[15:8];
			OP_SEND:    cmd_in.arg = '0;
			OP_RESTART: cmd_in.arg = s_axis_tdata[23:16];
			default:    cmd_in.arg = '0;
		endcase
	end

	assign s_axis_tready = (cnt_q != CC_W'(CMD_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (cnt_q != '0);
	assign pop           = cmd_valid && cmd_ready;
	assign cmd           = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CP_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + CP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CP_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + CP_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CC_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CC_W'(1);
			end
		end
	end

	a_cmd_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CC_W'(CMD_DEPTH))
		else $error("command queue overfilled");

endmodule

// ===== rtl/bdrq_back.sv =====
// back end: debounce state, report queue, retransmit countdown and result register
module bdrq_back import bdrq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_ready,
	input  logic [CFG_DATA_W-1:0] retransmit_ticks,
	output logic                  res_valid,
	output res_t                  res,
	input  logic                  res_ready
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t           state_q, state_n;
	logic [QA_W-1:0]  idx_q, idx_n;
	logic [QA_W-1:0]  head_q, head_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [BTN_W-1:0] pressed_q, pressed_n;
	logic [BTN_W-1:0] prev_q, prev_n;
	logic [RS_W-1:0]  rs_q, rs_n;
	logic [ACK_W-1:0] ack_q, ack_n;
	logic             out_valid_q;
	res_t             out_q;

	logic             can_load;
	logic             load;
	logic             advance;
	res_t             res_n;
	logic [BTN_W-1:0] tk_diff;
	logic [BTN_W-1:0] tk_agree;
	logic             tk_change;
	logic [BTN_W-1:0] tk_pressed;
	logic [RS_W-1:0]  rs_tick;

	logic             mem_we;
	logic [QA_W-1:0]  waddr;
	logic [QA_W-1:0]  raddr;
	logic [BTN_W-1:0] rdata;

	bdrq_ram #(
		.WIDTH(BTN_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (tk_pressed),
		.raddr  (raddr),
		.rdata_q(rdata)
	);

	assign can_load   = !out_valid_q || res_ready;
	assign cmd_ready  = (state_q == ST_IDLE) && can_load;
	assign tk_diff    = cmd.arg ^ pressed_q;
	assign tk_agree   = ~(cmd.arg ^ prev_q);
	assign tk_change  = |(tk_diff & tk_agree);
	assign tk_pressed = (pressed_q & ~tk_agree) | (cmd.arg & tk_agree);
	assign waddr      = qwrap(head_q, count_q[QA_W-1:0]);

	always_comb begin
		state_n   = state_q;
		idx_n     = idx_q;
		head_n    = head_q;
		count_n   = count_q;
		pressed_n = pressed_q;
		prev_n    = prev_q;
		rs_n      = rs_q;
		ack_n     = ack_q;
		load      = 1'b0;
		advance   = 1'b0;
		mem_we    = 1'b0;
		rs_tick   = rs_q;
		res_n.kind         = KIND_TICK;
		res_n.wake         = 1'b0;
		res_n.report_byte  = '0;
		res_n.report_index = '0;
		res_n.last         = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && can_load) begin
					unique case (cmd.op)
						OP_TICK: begin
							load = 1'b1;
							res_n.kind = KIND_TICK;
							if (tk_change) begin
								pressed_n = tk_pressed;
								if (count_q < CNT_W'(QUEUE_DEPTH)) begin
									mem_we     = 1'b1;
									count_n    = count_q + CNT_W'(1);
									res_n.wake = 1'b1;
									rs_tick    = RS_PENDING;
								end
							end
							prev_n = cmd.arg;
							if ((rs_tick & RS_COUNTING_OFF) == '0) begin
								rs_tick = rs_tick - RS_W'(1);
								if ((rs_tick & RS_COUNTING_OFF) != '0) begin
									res_n.wake = 1'b1;
								end
							end
							rs_n = rs_tick;
						end
						OP_ACK: begin
							load = 1'b1;
							res_n.kind = KIND_DONE;
							ack_n = ack_q + cmd.arg;
							if (cmd.arg >= ACK_W'(count_q)) begin
								count_n = '0;
								rs_n    = RS_ACKED;
							end else begin
								head_n  = qwrap(head_q, cmd.arg[QA_W-1:0]);
								count_n = count_q - CNT_W'(cmd.arg);
							end
						end
						OP_SEND: begin
							if (rs_q == RS_PENDING && count_q != '0) begin
								rs_n    = RS_W'(retransmit_ticks);
								state_n = ST_EMIT;
								idx_n   = '0;
							end else begin
								load = 1'b1;
								res_n.kind = KIND_NOSEND;
							end
						end
						OP_RESTART: begin
							load = 1'b1;
							res_n.kind = KIND_DONE;
							pressed_n  = cmd.arg;
							prev_n     = cmd.arg;
							ack_n      = '0;
							rs_n       = RS_ACKED;
							count_n    = '0;
							head_n     = '0;
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (can_load) begin
					load = 1'b1;
					res_n.kind         = KIND_REPORT;
					res_n.report_byte  = rdata;
					res_n.report_index = IDX_OUT_W'(idx_q);
					res_n.last         = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
					if (res_n.last) begin
						state_n = ST_IDLE;
						idx_n   = '0;
					end else begin
						advance = 1'b1;
						idx_n   = idx_q + QA_W'(1);
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
		res_n.pressed_state = pressed_n;
		res_n.report_total  = TOTAL_W'(count_n);
		res_n.ack_total     = ack_n;
	end

	// read one entry ahead when the current report byte leaves
	assign raddr = qwrap(head_q, advance ? idx_q + QA_W'(1) : idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			head_q      <= '0;
			count_q     <= '0;
			pressed_q   <= '0;
			prev_q      <= '0;
			rs_q        <= RS_ACKED;
			ack_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			idx_q     <= idx_n;
			head_q    <= head_n;
			count_q   <= count_n;
			pressed_q <= pressed_n;
			prev_q    <= prev_n;
			rs_q      <= rs_n;
			ack_q     <= ack_n;
			if (can_load) begin
				out_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			out_q <= res_n;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("report queue count beyond depth");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (count_q != '0) && (CNT_W'(idx_q) < count_q))
		else $error("report index outside queued reports");

	a_emit_counting: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !rs_q[RS_W-1])
		else $error("countdown not armed during report burst");

	a_rs_codes: assert property (@(posedge clk) disable iff (!arst_n)
		rs_q[RS_W-1] |-> (rs_q == RS_PENDING) || (rs_q == RS_ACKED))
		else $error("resend state holds an unknown marker");

endmodule

// ===== rtl/button_debounce_report_queue.sv =====
// top level of the button debounce report queue: config registers and stream ports
//
// Input stream: s_axis_tuser carries the mode (tick sample, acknowledge, send,
// restart), s_axis_tdata the sample bits, ack amount and initial state. Results
// leave on m_axis: tuser is the result kind, tlast marks the final result of one
// input transfer. The front decodes and masks each transfer into a two-entry
// command queue; the back runs one command at a time against the debounce state
// and the eight-entry report ram.
// A single result passes through the command queue into the result register; the
// first report byte of a send also waits for the ram read port to be primed.
// Tick, acknowledge, restart and an empty send each give one result; a send with
// queued reports primes the ram read port and then gives one report byte per cycle
// while m_axis_tready is high.
// Reset clears the debounce state, counters and config registers and marks the
// reports acknowledged; the report ram is not cleared, entries are read only
// after being written.
// When m_axis_tready is low with a result pending, the result register holds, the
// back stops, and once the command queue is full s_axis_tready drops.
module button_debounce_report_queue import bdrq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample_bits, ack_amount, initial_state
	input  logic [1:0]            s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// wake, pressed_state, report_byte, report_index, report_total, ack_total
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]            m_axis_tuser,  // kind
	output logic                  m_axis_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [BCNT_W-1:0]     active_buttons_q;
	logic [CFG_DATA_W-1:0] retransmit_q;
	logic                  cmd_valid;
	logic                  cmd_ready;
	cmd_t                  cmd;
	res_t                  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_buttons_q <= '0;
			retransmit_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUTTON_COUNT:     active_buttons_q <= cfg_data[BCNT_W-1:0];
				CFG_RETRANSMIT_TICKS: retransmit_q     <= cfg_data;
				default:              retransmit_q     <= retransmit_q;
			endcase
		end
	end

	bdrq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.active_buttons(active_buttons_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_ready     (cmd_ready)
	);

	bdrq_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_ready       (cmd_ready),
		.retransmit_ticks(retransmit_q),
		.res_valid       (m_axis_tvalid),
		.res             (res),
		.res_ready       (m_axis_tready)
	);

	assign m_axis_tdata = {res.ack_total, res.report_total, res.report_index,
		res.report_byte, res.pressed_state, res.wake};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the button debounce report queue
module tb;
	import bdrq_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		op_t        mode;
		logic [7:0] sample;
		logic [7:0] amount;
		logic [7:0] init;
	} btn_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // sample_bits, ack_amount, initial_state
	logic [1:0]            s_axis_tuser = '0;   // mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// wake, pressed_state, report_byte, report_index, report_total, ack_total
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;        // kind
	logic                  m_axis_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	button_debounce_report_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the debounce state and registers
	logic [BCNT_W-1:0] cfg_buttons = '0;
	logic [6:0]        cfg_resend_ticks = '0;
	logic [7:0]        sh_pressed = '0;
	logic [7:0]        sh_prev = '0;
	logic [7:0]        sh_reports [QUEUE_DEPTH];
	logic [3:0]        sh_count = '0;
	logic [7:0]        sh_resend = RS_ACKED;
	logic [7:0]        sh_acks = '0;

	btn_item_t stim_q [$];
	res_t      owed_results [$];
	btn_item_t cur_item;
	logic [7:0] gen_sample = '0;

	int offered_n = 0;
	int taken_n = 0;
	int results_seen = 0;
	int sink_seen = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int src_idle_max = 0;
	int sink_idle_max = 0;
	int stuck_cycles = 0;
	int errors = 0;
	int mode_seen [4] = '{0, 0, 0, 0};
	int reports_seen = 0;
	int wakes_seen = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic res_t make_result(kind_t kind, logic wake, logic [7:0] rbyte,
		logic [2:0] ridx, logic last);
		res_t r;
		r.kind = kind;
		r.wake = wake;
		r.pressed_state = sh_pressed;
		r.report_byte = rbyte;
		r.report_index = ridx;
		r.report_total = sh_count;
		r.ack_total = sh_acks;
		r.last = last;
		return r;
	endfunction

	task automatic debounce_and_report(input btn_item_t it);
		int n;
		int keep;
		logic [7:0] mask;
		logic [7:0] status;
		logic [7:0] diff;
		logic [7:0] agree;
		logic [7:0] dec;
		logic wake;
		wake = 1'b0;
		case (it.mode)
			OP_TICK: begin
				n = (cfg_buttons > MAX_BUTTONS) ? MAX_BUTTONS : int'(cfg_buttons);
				mask = (n >= 8) ? 8'hff : 8'((9'd1 << n) - 9'd1);
				status = it.sample & mask;
				diff = status ^ sh_pressed;
				if (diff != 0) begin
					agree = ~(status ^ sh_prev);
					if ((diff & agree) != 0) begin
						sh_pressed = (sh_pressed & ~agree) | (status & agree);
						if (sh_count < QUEUE_DEPTH) begin
							sh_reports[sh_count[2:0]] = sh_pressed;
							sh_count = sh_count + 4'd1;
							wake = 1'b1;
							sh_resend = RS_PENDING;
						end
					end
				end
				sh_prev = status;
				if ((sh_resend & RS_COUNTING_OFF) == 0) begin
					dec = sh_resend - 8'd1;
					if ((dec & RS_COUNTING_OFF) != 0) begin
						wake = 1'b1;
					end
					sh_resend = dec;
				end
				owed_results.push_back(make_result(KIND_TICK, wake, 8'h00, 3'd0, 1'b1));
			end
			OP_ACK: begin
				sh_acks = sh_acks + it.amount;
				if (it.amount >= sh_count) begin
					sh_count = '0;
					sh_resend = RS_ACKED;
				end else begin
					keep = int'(sh_count) - int'(it.amount);
					for (int i = 0; i < keep; i++) begin
						sh_reports[i] = sh_reports[i + int'(it.amount)];
					end
					sh_count = 4'(keep);
				end
				owed_results.push_back(make_result(KIND_DONE, 1'b0, 8'h00, 3'd0, 1'b1));
			end
			OP_SEND: begin
				if (sh_resend != RS_PENDING || sh_count == 0) begin
					owed_results.push_back(make_result(KIND_NOSEND, 1'b0, 8'h00, 3'd0, 1'b1));
				end else begin
					sh_resend = {1'b0, cfg_resend_ticks};
					for (int i = 0; i < int'(sh_count); i++) begin
						owed_results.push_back(make_result(KIND_REPORT, 1'b0, sh_reports[i],
							3'(i), (i + 1 == int'(sh_count))));
					end
				end
			end
			default: begin
				sh_pressed = it.init;
				sh_prev = it.init;
				sh_acks = '0;
				sh_resend = RS_ACKED;
				sh_count = '0;
				owed_results.push_back(make_result(KIND_DONE, 1'b0, 8'h00, 3'd0, 1'b1));
			end
		endcase
	endtask

	// sender: one item offered at a time, random gap after each transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || offered_n == taken_n) begin
				if (s_axis_tvalid) begin
					gap_left = $urandom_range(0, src_idle_max);
				end
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (stim_q.size() > 0) begin
					cur_item = stim_q.pop_front();
					offered_n++;
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= cur_item.mode;
					s_axis_tdata <= {cur_item.init, cur_item.amount, cur_item.sample};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall after each result, long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (results_seen != sink_seen) begin
				sink_seen = results_seen;
				stall_left = $urandom_range(0, sink_idle_max);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// input transfers feed the shadow, output transfers are checked, watchdog
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				taken_n++;
				mode_seen[cur_item.mode]++;
				debounce_and_report(cur_item);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.kind = kind_t'(m_axis_tuser);
				got.wake = m_axis_tdata[0];
				got.pressed_state = m_axis_tdata[8:1];
				got.report_byte = m_axis_tdata[16:9];
				got.report_index = m_axis_tdata[19:17];
				got.report_total = m_axis_tdata[23:20];
				got.ack_total = m_axis_tdata[31:24];
				got.last = m_axis_tlast;
				if (got.kind == KIND_REPORT) begin
					reports_seen++;
				end
				if (got.wake === 1'b1) begin
					wakes_seen++;
				end
				if (owed_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result transfer %0d: kind %0d data %h last %b",
							results_seen, m_axis_tuser, m_axis_tdata, m_axis_tlast);
					end
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch on result %0d:", results_seen);
							$display("  expected kind %0d wake %b pressed %h byte %h idx %0d total %0d acks %h last %b",
								want.kind, want.wake, want.pressed_state, want.report_byte,
								want.report_index, want.report_total, want.ack_total, want.last);
							$display("  actual   kind %0d wake %b pressed %h byte %h idx %0d total %0d acks %h last %b",
								got.kind, got.wake, got.pressed_state, got.report_byte,
								got.report_index, got.report_total, got.ack_total, got.last);
						end
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= STUCK_LIMIT) begin
					$display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	function automatic btn_item_t mk_item(op_t op, logic [7:0] sample, logic [7:0] amount,
		logic [7:0] init);
		btn_item_t it;
		it.mode = op;
		it.sample = sample;
		it.amount = amount;
		it.init = init;
		return it;
	endfunction

	// mostly repeated samples so that presses get through, other fields random
	function automatic btn_item_t random_item();
		btn_item_t it;
		int r;
		int pick;
		r = $urandom_range(0, 99);
		it = mk_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
		if (r < 60) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				gen_sample = 8'($urandom);
			end else if (pick < 5) begin
				gen_sample[$urandom_range(0, 7)] ^= 1'b1;
			end
			it.sample = gen_sample;
		end else if (r < 76) begin
			it.mode = OP_SEND;
		end else if (r < 92) begin
			it.mode = OP_ACK;
			if ($urandom_range(0, 4) != 0) begin
				it.amount = 8'($urandom_range(0, 4));
			end
		end else if (r < 95) begin
			it.mode = OP_RESTART;
		end
		return it;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BUTTON_COUNT) begin
			cfg_buttons = val[BCNT_W-1:0];
		end else begin
			cfg_resend_ticks = val[6:0];
		end
	endtask

	task automatic wait_drained();
		while (!(stim_q.size() == 0 && offered_n == taken_n && owed_results.size() == 0)) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input logic [6:0] bcount, input logic [6:0] ticks,
		input int src_max, input int sink_max, input bit squeeze);
		wait_drained();
		write_reg(CFG_BUTTON_COUNT, bcount);
		write_reg(CFG_RETRANSMIT_TICKS, ticks);
		src_idle_max = src_max;
		sink_idle_max = sink_max;
		if (squeeze) begin
			hold_requests++;
		end
		repeat (n) stim_q.push_back(random_item());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_BUTTON_COUNT, 7'd8);
		write_reg(CFG_RETRANSMIT_TICKS, 7'd0);
		src_idle_max = 3;
		sink_idle_max = 3;
		// empty queue, all pressed, retransmit after countdown, acks
		stim_q.push_back(mk_item(OP_SEND, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_RESTART, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_TICK, 8'hff, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_TICK, 8'hff, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_SEND, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_TICK, 8'hff, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_SEND, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_ACK, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_ACK, 8'h00, 8'hff, 8'h00));
		stim_q.push_back(mk_item(OP_RESTART, 8'h00, 8'h00, 8'h00));
		// staggered bits change state on every tick after the first and overflow the queue
		for (int i = 0; i < 10; i++) begin
			case (i % 4)
				0: stim_q.push_back(mk_item(OP_TICK, 8'h01, 8'h00, 8'h00));
				1: stim_q.push_back(mk_item(OP_TICK, 8'h03, 8'h00, 8'h00));
				2: stim_q.push_back(mk_item(OP_TICK, 8'h02, 8'h00, 8'h00));
				default: stim_q.push_back(mk_item(OP_TICK, 8'h00, 8'h00, 8'h00));
			endcase
		end
		stim_q.push_back(mk_item(OP_SEND, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_ACK, 8'h00, 8'h03, 8'h00));
		stim_q.push_back(mk_item(OP_TICK, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_SEND, 8'h00, 8'h00, 8'h00));
		stim_q.push_back(mk_item(OP_RESTART, 8'h00, 8'h00, 8'ha5));

		run_phase(70, 7'd8, 7'd3, 0, 0, 1'b0);
		run_phase(60, 7'd3, 7'd0, 6, 6, 1'b0);
		run_phase(40, 7'd0, 7'd127, 2, 5, 1'b0);
		run_phase(70, 7'd15, 7'd1, 0, 6, 1'b1);
		run_phase(60, 7'd5, 7'd10, 6, 0, 1'b0);
		run_phase(45, 7'd8, 7'($urandom_range(0, 127)), 3, 3, 1'b0);
		wait_drained();

		$display("run covered %0d ticks, %0d acks, %0d sends, %0d restarts",
			mode_seen[OP_TICK], mode_seen[OP_ACK], mode_seen[OP_SEND], mode_seen[OP_RESTART]);
		$display("%0d results checked: %0d report bytes, %0d with wake, %0d mismatches",
			results_seen, reports_seen, wakes_seen, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
